@@ hw/rtl/lctw_pkg.sv @@
// Shared constants, types and control structs of the load-cell tare and weigh block.
`timescale 1ns / 1ps

package lctw_pkg;

  // Converter code and fixed-point layout (24.8).
  localparam int SAMPLE_BITS = 24;
  localparam int FRAC_BITS   = 8;
  localparam int MAX_GROUP   = 10;
  localparam int CAL_DIVISOR = 10;

  localparam int SPR_W      = 4;
  localparam int THR_W      = 24;
  localparam int CNT8_W     = 8;
  localparam int GROUP_W    = 4;
  localparam int SUM_W      = SAMPLE_BITS + GROUP_W;
  localparam int TARE_W     = SAMPLE_BITS + FRAC_BITS;
  localparam int DIVIDEND_W = SUM_W + FRAC_BITS;
  localparam int DIVISOR_W  = 4;
  localparam int WEIGHT_W   = DIVIDEND_W + 2;

  // Configuration port.
  localparam int APB_ADDR_W = 5;
  localparam int APB_DATA_W = 32;

  // Queue depths.
  localparam int unsigned IN_DEPTH_DEF  = 4;
  localparam int unsigned OUT_DEPTH_DEF = 2;

  // Register reset values.
  localparam logic [SPR_W-1:0]  SPR_RESET  = SPR_W'(10);
  localparam logic [THR_W-1:0]  THR_RESET  = THR_W'(5000);
  localparam logic [THR_W-1:0]  TMIN_RESET = THR_W'(3000);
  localparam logic [CNT8_W-1:0] WARM_RESET = CNT8_W'(30);
  localparam logic [CNT8_W-1:0] CAL_RESET  = CNT8_W'(180);

  typedef enum logic [2:0] {
    REG_SAMPLES_PER_READING = 3'd0,
    REG_CHANGE_THRESHOLD    = 3'd1,
    REG_TARE_MINIMUM        = 3'd2,
    REG_WARMUP_SAMPLES      = 3'd3,
    REG_CALIBRATION_SAMPLES = 3'd4
  } reg_idx_e;

  typedef enum logic [1:0] {
    PH_CAL,
    PH_READY,
    PH_FAIL
  } phase_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_DIV,
    ST_CAL_END,
    ST_DIFF,
    ST_REPORT
  } back_state_e;

  typedef struct packed {
    logic [SPR_W-1:0]  spr;
    logic [THR_W-1:0]  thr;
    logic [THR_W-1:0]  tmin;
    logic [CNT8_W-1:0] warm;
    logic [CNT8_W-1:0] cal;
  } cfg_t;

  typedef struct packed {
    logic                  start;
    logic [DIVIDEND_W-1:0] dividend;
    logic [DIVISOR_W-1:0]  divisor;
  } div_req_t;

  typedef struct packed {
    logic                  done;
    logic [DIVIDEND_W-1:0] quotient;
  } div_rsp_t;

endpackage

@@ hw/rtl/lctw_fifo.sv @@
// Small first-in first-out queue used on the input side and the result side.
`timescale 1ns / 1ps

module lctw_fifo
  import lctw_pkg::*;
#(
  parameter int unsigned WIDTH = SAMPLE_BITS,
  parameter int unsigned DEPTH = IN_DEPTH_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] data_o,
  output logic             empty_o
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [AW-1:0]    wr_ptr_q, wr_ptr_d;
  logic [AW-1:0]    rd_ptr_q, rd_ptr_d;
  logic [CW-1:0]    count_q, count_d;
  logic             push_ok;
  logic             pop_ok;

  assign full_o  = (count_q == CW'(DEPTH));
  assign empty_o = (count_q == '0);
  assign push_ok = push_i && !full_o;
  assign pop_ok  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  // Pointer and fill-count update with wrap at the queue depth.
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_ok) begin
      wr_ptr_d = (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + AW'(1);
    end
    if (pop_ok) begin
      rd_ptr_d = (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + AW'(1);
    end
    if (push_ok && !pop_ok) begin
      count_d = count_q + CW'(1);
    end else if (!push_ok && pop_ok) begin
      count_d = count_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Storage is written at the write pointer only.
  always_ff @(posedge clk_i) begin
    if (push_ok) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

@@ hw/rtl/lctw_div.sv @@
// Iterative restoring divider, two quotient bits per cycle, narrow divisor.
`timescale 1ns / 1ps

module lctw_div
  import lctw_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_req_t req_i,
  output div_rsp_t rsp_o
);

  localparam int BITS_PER_CYCLE = 2;
  localparam int STEPS          = DIVIDEND_W / BITS_PER_CYCLE;
  localparam int CNT_W          = $clog2(STEPS + 1);

  logic                  busy_q;
  logic                  done_q;
  logic [CNT_W-1:0]      cnt_q;
  logic [DIVISOR_W-1:0]  rem_q, rem_step;
  logic [DIVIDEND_W-1:0] quo_q, quo_step;
  logic [DIVISOR_W-1:0]  div_q;

  // Two restoring steps: the dividend shifts out at the top while quotient bits shift in.
  always_comb begin : step_calc
    logic [DIVISOR_W:0]    trial;
    logic [DIVISOR_W-1:0]  rem_v;
    logic [DIVIDEND_W-1:0] quo_v;
    rem_v = rem_q;
    quo_v = quo_q;
    trial = '0;
    for (int i = 0; i < BITS_PER_CYCLE; i++) begin
      trial = {rem_v, quo_v[DIVIDEND_W-1]};
      quo_v = {quo_v[DIVIDEND_W-2:0], 1'b0};
      if (trial >= {1'b0, div_q}) begin
        trial    = trial - {1'b0, div_q};
        quo_v[0] = 1'b1;
      end
      rem_v = trial[DIVISOR_W-1:0];
    end
    rem_step = rem_v;
    quo_step = quo_v;
  end

  // Control: step counter and a one-cycle done pulse.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (req_i.start) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= CNT_W'(STEPS);
    end else if (busy_q) begin
      cnt_q <= cnt_q - CNT_W'(1);
      if (cnt_q == CNT_W'(1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      quo_q <= req_i.dividend;
      rem_q <= '0;
      div_q <= req_i.divisor;
    end else if (busy_q) begin
      quo_q <= quo_step;
      rem_q <= rem_step;
    end
  end

  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = quo_q;

endmodule

@@ hw/rtl/lctw_back.sv @@
// Sequencer that runs calibration, group averaging and change detection on queued samples.
`timescale 1ns / 1ps

module lctw_back
  import lctw_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  cfg_t                   cfg_i,
  input  logic                   in_valid_i,
  input  logic [SAMPLE_BITS-1:0] in_sample_i,
  output logic                   in_pop_o,
  input  logic                   out_full_i,
  output logic                   out_push_o,
  output logic [SAMPLE_BITS-1:0] out_weight_o,
  output div_req_t               div_req_o,
  input  div_rsp_t               div_rsp_i
);

  back_state_e              state_q, state_d;
  phase_e                   phase_q, phase_d;
  logic [CNT8_W-1:0]        cal_cnt_q, cal_cnt_d;
  logic [TARE_W-1:0]        tare_q, tare_d;
  logic [SUM_W-1:0]         sum_q, sum_d;
  logic [GROUP_W-1:0]       grp_q, grp_d;
  logic [TARE_W-1:0]        last_q, last_d;
  logic [SAMPLE_BITS-1:0]   sample_q, sample_d;
  logic [WEIGHT_W-1:0]      weight_q, weight_d;
  logic [WEIGHT_W-1:0]      diff_q, diff_d;

  logic [CNT8_W-1:0]        cal_cnt_inc;
  logic                     is_warmup;
  logic [SUM_W-1:0]         sum_inc;
  logic [GROUP_W-1:0]       grp_inc;
  logic [GROUP_W-1:0]       grp_n;
  logic                     group_done;
  logic [DIVIDEND_W-1:0]    cal_dividend;
  logic [DIVIDEND_W-1:0]    avg_dividend;
  logic [WEIGHT_W-1:0]      weight_calc;
  logic [WEIGHT_W-1:0]      diff_mag;
  logic                     over_thr;
  logic [TARE_W-1:0]        new_last;
  logic                     take_item;

  // Counters and operands derived from the current state.
  assign cal_cnt_inc  = cal_cnt_q + CNT8_W'(1);
  assign is_warmup    = (cal_cnt_inc <= cfg_i.warm);
  assign sum_inc      = sum_q + SUM_W'(sample_q);
  assign grp_inc      = grp_q + GROUP_W'(1);
  assign grp_n        = (cfg_i.spr == '0) ? GROUP_W'(1) :
                        (cfg_i.spr > SPR_W'(MAX_GROUP)) ? GROUP_W'(MAX_GROUP) :
                        GROUP_W'(cfg_i.spr);
  assign group_done   = (grp_inc >= grp_n);
  assign cal_dividend = (DIVIDEND_W'(tare_q) << 1) +
                        (DIVIDEND_W'(sample_q) << (FRAC_BITS + 3));
  assign avg_dividend = {sum_inc, {FRAC_BITS{1'b0}}};
  assign weight_calc  = WEIGHT_W'(div_rsp_i.quotient) - WEIGHT_W'(tare_q);
  assign diff_mag     = diff_q[WEIGHT_W-1] ? (~diff_q + WEIGHT_W'(1)) : diff_q;
  assign over_thr     = (diff_mag > WEIGHT_W'({cfg_i.thr, {FRAC_BITS{1'b0}}}));
  assign new_last     = weight_q[WEIGHT_W-1] ? '0 : weight_q[TARE_W-1:0];
  assign take_item    = in_valid_i && !out_full_i;

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (take_item) begin
          state_d = ST_DISPATCH;
        end
      end
      ST_DISPATCH: begin
        unique case (phase_q)
          PH_CAL:   state_d = is_warmup ? ST_CAL_END : ST_DIV;
          PH_READY: state_d = group_done ? ST_DIV : ST_IDLE;
          default:  state_d = ST_IDLE;
        endcase
      end
      ST_DIV: begin
        if (div_rsp_i.done) begin
          state_d = (phase_q == PH_CAL) ? ST_CAL_END : ST_DIFF;
        end
      end
      ST_CAL_END: state_d = ST_IDLE;
      ST_DIFF:    state_d = ST_REPORT;
      ST_REPORT:  state_d = ST_IDLE;
      default:    state_d = ST_IDLE;
    endcase
  end

  // Outputs of the sequencer: queue handshakes and divider requests.
  always_comb begin
    in_pop_o           = 1'b0;
    out_push_o         = 1'b0;
    div_req_o.start    = 1'b0;
    div_req_o.dividend = avg_dividend;
    div_req_o.divisor  = grp_n;
    unique case (state_q)
      ST_IDLE: begin
        in_pop_o = take_item;
      end
      ST_DISPATCH: begin
        if (phase_q == PH_CAL) begin
          div_req_o.start    = !is_warmup;
          div_req_o.dividend = cal_dividend;
          div_req_o.divisor  = DIVISOR_W'(CAL_DIVISOR);
        end else if (phase_q == PH_READY) begin
          div_req_o.start = group_done;
        end
      end
      ST_REPORT: begin
        out_push_o = over_thr;
      end
      default: begin
      end
    endcase
  end

  assign out_weight_o = new_last[TARE_W-1:FRAC_BITS];

  // Datapath updates.
  always_comb begin
    phase_d   = phase_q;
    cal_cnt_d = cal_cnt_q;
    tare_d    = tare_q;
    sum_d     = sum_q;
    grp_d     = grp_q;
    last_d    = last_q;
    sample_d  = sample_q;
    weight_d  = weight_q;
    diff_d    = diff_q;
    case (state_q)
      ST_IDLE: begin
        if (take_item) begin
          sample_d = in_sample_i;
        end
      end
      ST_DISPATCH: begin
        if (phase_q == PH_CAL) begin
          cal_cnt_d = cal_cnt_inc;
          if (is_warmup) begin
            tare_d = {sample_q, {FRAC_BITS{1'b0}}};
          end
        end else if (phase_q == PH_READY) begin
          if (group_done) begin
            sum_d = '0;
            grp_d = '0;
          end else begin
            sum_d = sum_inc;
            grp_d = grp_inc;
          end
        end
      end
      ST_DIV: begin
        if (div_rsp_i.done) begin
          if (phase_q == PH_CAL) begin
            tare_d = div_rsp_i.quotient[TARE_W-1:0];
          end else begin
            weight_d = weight_calc;
          end
        end
      end
      ST_CAL_END: begin
        // Calibration ends once the count reaches the configured length.
        if (cal_cnt_q >= cfg_i.cal) begin
          phase_d = (tare_q > {cfg_i.tmin, {FRAC_BITS{1'b0}}}) ? PH_READY : PH_FAIL;
        end
      end
      ST_DIFF: begin
        diff_d = weight_q - WEIGHT_W'(last_q);
      end
      ST_REPORT: begin
        if (over_thr) begin
          last_d = new_last;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      phase_q   <= PH_CAL;
      cal_cnt_q <= '0;
      tare_q    <= '0;
      sum_q     <= '0;
      grp_q     <= '0;
      last_q    <= '0;
    end else begin
      state_q   <= state_d;
      phase_q   <= phase_d;
      cal_cnt_q <= cal_cnt_d;
      tare_q    <= tare_d;
      sum_q     <= sum_d;
      grp_q     <= grp_d;
      last_q    <= last_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sample_q <= sample_d;
    weight_q <= weight_d;
    diff_q   <= diff_d;
  end

endmodule

@@ hw/rtl/load_cell_tare_and_weigh.sv @@
// Top level of the load-cell tare and weigh block: queues, configuration registers, sequencer.
`timescale 1ns / 1ps

// Each item is one raw converter code; its top bit is flipped to form an offset-binary
// sample, which waits in the input queue until the sequencer takes it. The first
// calibration samples set the tare, after which the block either weighs or stays failed
// and swallows every item without a result. When weighing, every group of
// samples_per_reading items (zero taken as one, at most 10) gives one average; a result
// item is queued only when the weight above tare moves by more than change_threshold
// counts (kg = counts / 100000). In the sequencer, an item that falls inside a group or
// arrives after a failed calibration passes through dispatch only, and a warmup sample
// also through the calibration end state. An item that refines the tare or closes a
// group waits on the shared divider: it retires two quotient bits per cycle over a
// 36-bit dividend and holds the sequencer until done. Configuration registers should be
// written only while the block is idle.
module load_cell_tare_and_weigh
  import lctw_pkg::*;
#(
  parameter int unsigned IN_DEPTH  = IN_DEPTH_DEF,
  parameter int unsigned OUT_DEPTH = OUT_DEPTH_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // Input queue side.
  input  logic                   push,
  output logic                   full,
  input  logic [SAMPLE_BITS-1:0] raw_code_i,
  // Result queue side.
  output logic                   empty,
  input  logic                   pop,
  output logic [SAMPLE_BITS-1:0] weight_counts_o,
  // Configuration port.
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [APB_ADDR_W-1:0]  paddr,
  input  logic [APB_DATA_W-1:0]  pwdata,
  output logic [APB_DATA_W-1:0]  prdata,
  output logic                   pready
);

  cfg_t                   cfg_q, cfg_d;
  logic                   cfg_write;
  reg_idx_e               cfg_idx;
  logic [SAMPLE_BITS-1:0] sample_in;
  logic [SAMPLE_BITS-1:0] sample_head;
  logic                   in_empty;
  logic                   in_pop;
  logic                   out_full;
  logic                   out_push;
  logic [SAMPLE_BITS-1:0] out_weight;
  div_req_t               div_req;
  div_rsp_t               div_rsp;

  // Configuration registers.
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  assign cfg_idx   = reg_idx_e'(paddr[APB_ADDR_W-1:2]);

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_write) begin
      unique case (cfg_idx)
        REG_SAMPLES_PER_READING: cfg_d.spr  = pwdata[SPR_W-1:0];
        REG_CHANGE_THRESHOLD:    cfg_d.thr  = pwdata[THR_W-1:0];
        REG_TARE_MINIMUM:        cfg_d.tmin = pwdata[THR_W-1:0];
        REG_WARMUP_SAMPLES:      cfg_d.warm = pwdata[CNT8_W-1:0];
        REG_CALIBRATION_SAMPLES: cfg_d.cal  = pwdata[CNT8_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_SAMPLES_PER_READING: prdata = APB_DATA_W'(cfg_q.spr);
      REG_CHANGE_THRESHOLD:    prdata = APB_DATA_W'(cfg_q.thr);
      REG_TARE_MINIMUM:        prdata = APB_DATA_W'(cfg_q.tmin);
      REG_WARMUP_SAMPLES:      prdata = APB_DATA_W'(cfg_q.warm);
      REG_CALIBRATION_SAMPLES: prdata = APB_DATA_W'(cfg_q.cal);
      default:                 prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.spr  <= SPR_RESET;
      cfg_q.thr  <= THR_RESET;
      cfg_q.tmin <= TMIN_RESET;
      cfg_q.warm <= WARM_RESET;
      cfg_q.cal  <= CAL_RESET;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // Front: convert the two's-complement code to offset binary and queue it.
  assign sample_in = {~raw_code_i[SAMPLE_BITS-1], raw_code_i[SAMPLE_BITS-2:0]};

  lctw_fifo #(
    .WIDTH(SAMPLE_BITS),
    .DEPTH(IN_DEPTH)
  ) u_in_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .data_i (sample_in),
    .full_o (full),
    .pop_i  (in_pop),
    .data_o (sample_head),
    .empty_o(in_empty)
  );

  // Back: sequencer and shared divider.
  lctw_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .in_valid_i  (!in_empty),
    .in_sample_i (sample_head),
    .in_pop_o    (in_pop),
    .out_full_i  (out_full),
    .out_push_o  (out_push),
    .out_weight_o(out_weight),
    .div_req_o   (div_req),
    .div_rsp_i   (div_rsp)
  );

  lctw_div u_div (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (div_req),
    .rsp_o (div_rsp)
  );

  // Result queue.
  lctw_fifo #(
    .WIDTH(SAMPLE_BITS),
    .DEPTH(OUT_DEPTH)
  ) u_out_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (out_push),
    .data_i (out_weight),
    .full_o (out_full),
    .pop_i  (pop),
    .data_o (weight_counts_o),
    .empty_o(empty)
  );

endmodule

@@ bench/tb.sv @@
// Testbench of the load-cell tare and weigh block: directed and random items, predicted weights.
`timescale 1ns / 1ps

module tb;
  import lctw_pkg::*;

  localparam int unsigned CYCLE_LIMIT   = 1_000_000;
  localparam int unsigned SETTLE_CYCLES = 150;
  localparam int unsigned MAX_REPORTS   = 40;

  logic                   clk_i   = 1'b0;
  logic                   rst_ni  = 1'b0;
  logic                   push    = 1'b0;
  logic                   full;
  logic [SAMPLE_BITS-1:0] raw_code_i = '0;
  logic                   empty;
  logic                   pop     = 1'b0;
  logic [SAMPLE_BITS-1:0] weight_counts_o;
  logic                   psel    = 1'b0;
  logic                   penable = 1'b0;
  logic                   pwrite  = 1'b0;
  logic [APB_ADDR_W-1:0]  paddr   = '0;
  logic [APB_DATA_W-1:0]  pwdata  = '0;
  logic [APB_DATA_W-1:0]  prdata;
  logic                   pready;

  // Predicted state of the block and its registers.
  cfg_t                   cfg;
  phase_e                 weigh_phase;
  logic [CNT8_W-1:0]      cal_count;
  logic [TARE_W-1:0]      tare;
  logic [SUM_W-1:0]       sample_sum;
  logic [GROUP_W-1:0]     group_count;
  logic [TARE_W-1:0]      last_weight;
  logic [SAMPLE_BITS-1:0] expected_weights[$];

  int unsigned error_count   = 0;
  int unsigned results_seen  = 0;
  int unsigned cycle_count   = 0;
  int unsigned send_idle_pct = 0;
  int unsigned pop_stall_pct = 0;

  load_cell_tare_and_weigh u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .push           (push),
    .full           (full),
    .raw_code_i     (raw_code_i),
    .empty          (empty),
    .pop            (pop),
    .weight_counts_o(weight_counts_o),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  // Clock with a 10 ns period.
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Run limit.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  task automatic report_mismatch(input string what, input longint unsigned got,
                                 input longint unsigned want);
    if (error_count < MAX_REPORTS) begin
      $display("MISMATCH %s: got 0x%0h, expected 0x%0h at %0t", what, got, want, $time);
    end
    error_count++;
  endtask

  // The receiver stalls at random in the share of cycles that pop_stall_pct gives.
  always @(negedge clk_i) begin
    pop <= ($urandom_range(99) >= pop_stall_pct);
  end

  // Each accepted weight item is compared with the oldest predicted one.
  always @(posedge clk_i) begin
    if (rst_ni && pop && !empty) begin
      if (expected_weights.size() == 0) begin
        report_mismatch("weight with none predicted", 64'(weight_counts_o), 64'(0));
      end else begin
        if (weight_counts_o !== expected_weights[0]) begin
          report_mismatch("weight_counts", 64'(weight_counts_o), 64'(expected_weights[0]));
        end
        void'(expected_weights.pop_front());
      end
      results_seen++;
    end
  end

  // Works out what one accepted converter code does to the block state.
  task automatic weigh_sample(input logic [SAMPLE_BITS-1:0] code);
    logic [SAMPLE_BITS-1:0] sample;
    longint unsigned        divisor;
    longint unsigned        avg;
    longint                 weight;
    longint                 delta;
    sample = code ^ {1'b1, {(SAMPLE_BITS-1){1'b0}}};
    case (weigh_phase)
      PH_CAL: begin
        cal_count = cal_count + CNT8_W'(1);
        if (cal_count <= cfg.warm) begin
          tare = {sample, 8'h00};
        end else begin
          tare = 32'((64'(tare) * 2 + 64'(sample) * 2048) / 10);
        end
        if (cal_count >= cfg.cal) begin
          weigh_phase = (tare > {cfg.tmin, 8'h00}) ? PH_READY : PH_FAIL;
        end
      end
      PH_READY: begin
        divisor = 64'(cfg.spr);
        if (divisor < 1) divisor = 1;
        if (divisor > 64'(MAX_GROUP)) divisor = 64'(MAX_GROUP);
        sample_sum  = sample_sum + SUM_W'(sample);
        group_count = group_count + GROUP_W'(1);
        if (64'(group_count) >= divisor) begin
          avg         = (64'(sample_sum) << 8) / divisor;
          weight      = longint'(avg) - longint'(tare);
          sample_sum  = '0;
          group_count = '0;
          delta       = weight - longint'(last_weight);
          if (delta < 0) delta = -delta;
          if (delta > (longint'(cfg.thr) << 8)) begin
            last_weight = (weight < 0) ? '0 : weight[31:0];
            expected_weights.push_back(last_weight[31:8]);
          end
        end
      end
      default: begin
      end
    endcase
  endtask

  // Sends one converter code; starts and ends at a falling edge.
  task automatic send_code(input logic [SAMPLE_BITS-1:0] code);
    while ($urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      @(negedge clk_i);
    end
    push       <= 1'b1;
    raw_code_i <= code;
    do @(posedge clk_i); while (full);
    weigh_sample(code);
    @(negedge clk_i);
  endtask

  // Holds the sender until every predicted weight has come and the sequencer is quiet.
  task automatic wait_settled();
    push <= 1'b0;
    while (expected_weights.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  function automatic logic [APB_DATA_W-1:0] reg_value(input reg_idx_e idx);
    case (idx)
      REG_SAMPLES_PER_READING: return 32'(cfg.spr);
      REG_CHANGE_THRESHOLD:    return 32'(cfg.thr);
      REG_TARE_MINIMUM:        return 32'(cfg.tmin);
      REG_WARMUP_SAMPLES:      return 32'(cfg.warm);
      default:                 return 32'(cfg.cal);
    endcase
  endfunction

  // One register access; psel stays high so that a second access can follow directly.
  task automatic apb_access(input reg_idx_e idx, input logic is_write,
                            input logic [APB_DATA_W-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= is_write;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (is_write) begin
      case (idx)
        REG_SAMPLES_PER_READING: cfg.spr  = data[SPR_W-1:0];
        REG_CHANGE_THRESHOLD:    cfg.thr  = data[THR_W-1:0];
        REG_TARE_MINIMUM:        cfg.tmin = data[THR_W-1:0];
        REG_WARMUP_SAMPLES:      cfg.warm = data[CNT8_W-1:0];
        default:                 cfg.cal  = data[CNT8_W-1:0];
      endcase
    end else if (prdata !== reg_value(idx)) begin
      report_mismatch($sformatf("register %s", idx.name()), 64'(prdata),
                      64'(reg_value(idx)));
    end
    @(negedge clk_i);
  endtask

  task automatic apb_release();
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Writes a register and reads it back.
  task automatic config_reg(input reg_idx_e idx, input logic [APB_DATA_W-1:0] data);
    apb_access(idx, 1'b1, data);
    apb_access(idx, 1'b0, '0);
    apb_release();
  endtask

  task automatic test_reset_values();
    reg_idx_e idx;
    idx = idx.first();
    repeat (idx.num()) begin
      apb_access(idx, 1'b0, '0);
      idx = idx.next();
    end
    apb_release();
  endtask

  // Warmup and refined tare samples at the code extremes, then a shortened calibration
  // whose last sample, now inside the warmup, sets the tare directly.
  task automatic test_calibration();
    logic [SAMPLE_BITS-1:0] codes[8];
    codes = '{24'h000000, 24'hFFFFFF, 24'h800000, 24'h7FFFFF,
              24'hFFFFFF, 24'h000000, 24'h555555, 24'hAAAAAA};
    config_reg(REG_WARMUP_SAMPLES, 4);
    config_reg(REG_CALIBRATION_SAMPLES, 255);
    config_reg(REG_TARE_MINIMUM, 32'h001F_FFFF);
    foreach (codes[i]) send_code(codes[i]);
    wait_settled();
    config_reg(REG_WARMUP_SAMPLES, 255);
    config_reg(REG_CALIBRATION_SAMPLES, 0);
    send_code(24'hA00000);
    wait_settled();
  endtask

  // Group size zero used as one, zero threshold: largest, negative and unchanged weights.
  // Then the largest threshold lets nothing through.
  task automatic test_response_extremes();
    config_reg(REG_SAMPLES_PER_READING, 0);
    config_reg(REG_CHANGE_THRESHOLD, 0);
    send_code(24'hFFFFFF);
    send_code(24'h7FFFFF);
    send_code(24'h800000);
    send_code(24'hA00000);
    wait_settled();
    config_reg(REG_SAMPLES_PER_READING, 1);
    config_reg(REG_CHANGE_THRESHOLD, 32'h00FF_FFFF);
    send_code(24'h7FFFFF);
    send_code(24'h800000);
    wait_settled();
  endtask

  // An oversized group is cut short by a lowered group size; calibration registers
  // no longer matter once weighing.
  task automatic test_group_limits();
    config_reg(REG_SAMPLES_PER_READING, 15);
    config_reg(REG_CHANGE_THRESHOLD, 0);
    config_reg(REG_TARE_MINIMUM, 32'h00FF_FFFF);
    config_reg(REG_WARMUP_SAMPLES, 0);
    config_reg(REG_CALIBRATION_SAMPLES, 1);
    send_code(24'h123456);
    send_code(24'hFEDCBA);
    send_code(24'h3C3C3C);
    wait_settled();
    config_reg(REG_SAMPLES_PER_READING, 1);
    send_code(24'hC3C3C3);
    wait_settled();
    config_reg(REG_TARE_MINIMUM, 0);
  endtask

  task automatic pick_settings();
    logic [THR_W-1:0] thr;
    case ($urandom_range(5))
      0:       thr = '0;
      1:       thr = THR_W'($urandom_range(2000));
      2:       thr = THR_W'($urandom_range(24'h010000));
      3:       thr = THR_W'($urandom_range(24'h200000));
      4:       thr = 24'hFFFFFF;
      default: thr = THR_RESET;
    endcase
    config_reg(REG_SAMPLES_PER_READING, $urandom_range(15));
    config_reg(REG_CHANGE_THRESHOLD, 32'(thr));
    if ($urandom_range(3) == 0) begin
      config_reg(REG_TARE_MINIMUM, $urandom_range(24'hFFFFFF));
      config_reg(REG_WARMUP_SAMPLES, $urandom_range(255));
      config_reg(REG_CALIBRATION_SAMPLES, $urandom_range(255));
    end
  endtask

  // Random weighing: a load level that jumps now and then, small noise around it,
  // and some fully random codes. New settings every 75 items.
  task automatic test_random_weighing(input int unsigned sender_pct,
                                      input int unsigned receiver_pct,
                                      input int unsigned item_goal);
    int unsigned            sent;
    int unsigned            seen_at_start;
    logic [SAMPLE_BITS-1:0] level;
    logic [SAMPLE_BITS-1:0] code;
    sent          = 0;
    seen_at_start = results_seen;
    send_idle_pct = sender_pct;
    pop_stall_pct = receiver_pct;
    level         = SAMPLE_BITS'($urandom);
    while (sent < item_goal ||
           (results_seen - seen_at_start < 12 && sent < 3 * item_goal)) begin
      if (sent % 75 == 0) begin
        wait_settled();
        pick_settings();
      end
      if ($urandom_range(99) < 12) level = SAMPLE_BITS'($urandom);
      if ($urandom_range(9) == 0) begin
        code = SAMPLE_BITS'($urandom);
      end else begin
        code = level + SAMPLE_BITS'($urandom_range(511)) - SAMPLE_BITS'(256);
      end
      send_code(code);
      sent++;
    end
    wait_settled();
  endtask

  initial begin
    cfg = '{spr: SPR_RESET, thr: THR_RESET, tmin: TMIN_RESET, warm: WARM_RESET,
            cal: CAL_RESET};
    weigh_phase = PH_CAL;
    cal_count   = '0;
    tare        = '0;
    sample_sum  = '0;
    group_count = '0;
    last_weight = '0;
    repeat (7) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    test_reset_values();
    test_calibration();
    test_response_extremes();
    test_group_limits();
    test_random_weighing(0, 0, 450);
    test_random_weighing(60, 0, 450);
    test_random_weighing(0, 60, 450);
    test_random_weighing(15, 15, 450);
    if (error_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
